>>> rtl/gbfp_pkg.sv
package gbfp_pkg;

   // Parser phase codes
   typedef enum logic [3:0] {
      PH_SYNC1   = 4'd0,
      PH_SYNC2   = 4'd1,
      PH_CLASS   = 4'd2,
      PH_ID      = 4'd3,
      PH_LEN_LO  = 4'd4,
      PH_LEN_HI  = 4'd5,
      PH_PAYLOAD = 4'd6,
      PH_CK_A    = 4'd7,
      PH_CK_B    = 4'd8
   } phase_type;

   // Result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_END     = 1'b1;

   // Frame-end status codes
   localparam logic [1:0] STATUS_GOOD     = 2'd0;
   localparam logic [1:0] STATUS_CKSUM    = 2'd1;
   localparam logic [1:0] STATUS_OVER_LEN = 2'd2;

   // Register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_FIRST      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_SECOND     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD_LEN = 2'd2;
   localparam int unsigned CSR_DATA_W = 16;

   // Register reset values
   localparam logic [7:0]  SYNC_FIRST_RST      = 8'hB5;
   localparam logic [7:0]  SYNC_SECOND_RST     = 8'h62;
   localparam logic [15:0] MAX_PAYLOAD_LEN_RST = 16'd1024;

   typedef struct packed {
      logic [7:0]  sync_first;
      logic [7:0]  sync_second;
      logic [15:0] max_payload_len;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  sum_a;
      logic [7:0]  sum_b;
      logic [7:0]  cur_class;
      logic [7:0]  cur_id;
      logic [15:0] cur_length;
      logic [15:0] payload_count;
      logic [7:0]  got_sum_a;
   } frame_state_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data;
      logic [15:0] byte_index;
      logic [7:0]  msg_class;
      logic [7:0]  msg_id;
      logic [15:0] payload_length;
      logic [1:0]  status;
   } result_type;

endpackage

>>> rtl/gbfp_step.sv
module gbfp_step (
   input  gbfp_pkg::cfg_type         cfg,
   input  gbfp_pkg::frame_state_type cur,
   input  logic [7:0]                rx_byte,
   output gbfp_pkg::frame_state_type nxt,
   output logic                      has_result,
   output gbfp_pkg::result_type      result
);

   logic [7:0]  add_a;
   logic [7:0]  add_b;
   logic [15:0] full_length;
   logic [15:0] count_inc;
   logic        over_limit;
   logic        cksum_ok;

   // Shared arithmetic for the running sums, length checks and checksum compare
   assign add_a       = cur.sum_a + rx_byte;
   assign add_b       = cur.sum_b + add_a;
   assign full_length = {rx_byte, cur.cur_length[7:0]};
   assign count_inc   = cur.payload_count + 16'd1;
   assign over_limit  = full_length > cfg.max_payload_len;
   assign cksum_ok    = (cur.got_sum_a == cur.sum_a) && (rx_byte == cur.sum_b);

   // Next phase
   always_comb begin
      case (cur.phase)
         gbfp_pkg::PH_SYNC2: begin
            if (rx_byte == cfg.sync_second) begin
               nxt.phase = gbfp_pkg::PH_CLASS;
            end else if (rx_byte == cfg.sync_first) begin
               nxt.phase = gbfp_pkg::PH_SYNC2;
            end else begin
               nxt.phase = gbfp_pkg::PH_SYNC1;
            end
         end
         gbfp_pkg::PH_CLASS:  nxt.phase = gbfp_pkg::PH_ID;
         gbfp_pkg::PH_ID:     nxt.phase = gbfp_pkg::PH_LEN_LO;
         gbfp_pkg::PH_LEN_LO: nxt.phase = gbfp_pkg::PH_LEN_HI;
         gbfp_pkg::PH_LEN_HI: begin
            if (over_limit) begin
               nxt.phase = gbfp_pkg::PH_SYNC1;
            end else if (full_length == 16'd0) begin
               nxt.phase = gbfp_pkg::PH_CK_A;
            end else begin
               nxt.phase = gbfp_pkg::PH_PAYLOAD;
            end
         end
         gbfp_pkg::PH_PAYLOAD: begin
            nxt.phase = (count_inc >= cur.cur_length) ? gbfp_pkg::PH_CK_A
                                                      : gbfp_pkg::PH_PAYLOAD;
         end
         gbfp_pkg::PH_CK_A: nxt.phase = gbfp_pkg::PH_CK_B;
         gbfp_pkg::PH_CK_B: nxt.phase = gbfp_pkg::PH_SYNC1;
         default: begin
            nxt.phase = (rx_byte == cfg.sync_first) ? gbfp_pkg::PH_SYNC2
                                                    : gbfp_pkg::PH_SYNC1;
         end
      endcase
   end

   // Frame fields, running sums and the result word
   always_comb begin
      nxt.sum_a         = cur.sum_a;
      nxt.sum_b         = cur.sum_b;
      nxt.cur_class     = cur.cur_class;
      nxt.cur_id        = cur.cur_id;
      nxt.cur_length    = cur.cur_length;
      nxt.payload_count = cur.payload_count;
      nxt.got_sum_a     = cur.got_sum_a;
      has_result        = 1'b0;
      result.kind           = gbfp_pkg::KIND_PAYLOAD;
      result.data           = 8'd0;
      result.byte_index     = 16'd0;
      result.msg_class      = cur.cur_class;
      result.msg_id         = cur.cur_id;
      result.payload_length = cur.cur_length;
      result.status         = gbfp_pkg::STATUS_GOOD;
      case (cur.phase)
         gbfp_pkg::PH_CLASS: begin
            // restart the sums on the class byte
            nxt.sum_a     = rx_byte;
            nxt.sum_b     = rx_byte;
            nxt.cur_class = rx_byte;
         end
         gbfp_pkg::PH_ID: begin
            nxt.sum_a  = add_a;
            nxt.sum_b  = add_b;
            nxt.cur_id = rx_byte;
         end
         gbfp_pkg::PH_LEN_LO: begin
            nxt.sum_a      = add_a;
            nxt.sum_b      = add_b;
            nxt.cur_length = {8'd0, rx_byte};
         end
         gbfp_pkg::PH_LEN_HI: begin
            nxt.sum_a         = add_a;
            nxt.sum_b         = add_b;
            nxt.cur_length    = full_length;
            nxt.payload_count = 16'd0;
            // drop an oversized frame right away
            if (over_limit) begin
               has_result            = 1'b1;
               result.kind           = gbfp_pkg::KIND_END;
               result.payload_length = full_length;
               result.status         = gbfp_pkg::STATUS_OVER_LEN;
            end
         end
         gbfp_pkg::PH_PAYLOAD: begin
            nxt.sum_a         = add_a;
            nxt.sum_b         = add_b;
            nxt.payload_count = count_inc;
            has_result        = 1'b1;
            result.data       = rx_byte;
            result.byte_index = cur.payload_count;
         end
         gbfp_pkg::PH_CK_A: begin
            nxt.got_sum_a = rx_byte;
         end
         gbfp_pkg::PH_CK_B: begin
            has_result    = 1'b1;
            result.kind   = gbfp_pkg::KIND_END;
            result.status = cksum_ok ? gbfp_pkg::STATUS_GOOD : gbfp_pkg::STATUS_CKSUM;
         end
         default: begin
         end
      endcase
   end

endmodule

>>> rtl/gnss_binary_frame_parser_top.sv
// Binary frame parser with an 8-bit Fletcher check. It takes one received byte
// per cycle on the req_ side; every byte is first held in an input register and
// the frame state machine then consumes it, loading a result into the rsp_
// output register when it makes one (each payload byte with its index, and one
// frame-end word per frame with its status). Sustained rate is one byte per
// cycle as long as rsp_stall is low. req_stall rises only when the input
// register holds a byte that makes a result while the output register is full
// and stalled; bytes that make no result move on regardless. The csr_ port
// writes the sync bytes and the payload length limit; write it only while idle.
module gnss_binary_frame_parser_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_rx_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_kind,
   output logic [7:0]                            rsp_data,
   output logic [15:0]                           rsp_byte_index,
   output logic [7:0]                            rsp_msg_class,
   output logic [7:0]                            rsp_msg_id,
   output logic [15:0]                           rsp_payload_length,
   output logic [1:0]                            rsp_status,
   input  logic                                  csr_write_en,
   input  logic [gbfp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [gbfp_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   gbfp_pkg::cfg_type         cfg_ff;
   gbfp_pkg::frame_state_type state_ff;
   gbfp_pkg::frame_state_type state_in;
   gbfp_pkg::result_type      result_in;
   gbfp_pkg::result_type      rsp_ff;
   logic                      has_result;
   logic                      in_valid_ff;
   logic [7:0]                in_byte_ff;
   logic                      rsp_valid_ff;
   logic                      advance;
   logic                      req_accept;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first      <= gbfp_pkg::SYNC_FIRST_RST;
         cfg_ff.sync_second     <= gbfp_pkg::SYNC_SECOND_RST;
         cfg_ff.max_payload_len <= gbfp_pkg::MAX_PAYLOAD_LEN_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            gbfp_pkg::CSR_SYNC_FIRST:      cfg_ff.sync_first      <= csr_wdata[7:0];
            gbfp_pkg::CSR_SYNC_SECOND:     cfg_ff.sync_second     <= csr_wdata[7:0];
            gbfp_pkg::CSR_MAX_PAYLOAD_LEN: cfg_ff.max_payload_len <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Frame state machine logic
   gbfp_step u_step (
      .cfg        (cfg_ff),
      .cur        (state_ff),
      .rx_byte    (in_byte_ff),
      .nxt        (state_in),
      .has_result (has_result),
      .result     (result_in)
   );

   // Advance the held byte unless its result has nowhere to go
   assign advance    = in_valid_ff && (!has_result || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase         <= gbfp_pkg::PH_SYNC1;
         state_ff.sum_a         <= 8'd0;
         state_ff.sum_b         <= 8'd0;
         state_ff.cur_class     <= 8'd0;
         state_ff.cur_id        <= 8'd0;
         state_ff.cur_length    <= 16'd0;
         state_ff.payload_count <= 16'd0;
         state_ff.got_sum_a     <= 8'd0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_data           = rsp_ff.data;
   assign rsp_byte_index     = rsp_ff.byte_index;
   assign rsp_msg_class      = rsp_ff.msg_class;
   assign rsp_msg_id         = rsp_ff.msg_id;
   assign rsp_payload_length = rsp_ff.payload_length;
   assign rsp_status         = rsp_ff.status;

   // A payload word always carries good status
   a_payload_status : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == gbfp_pkg::KIND_PAYLOAD) |-> rsp_status == gbfp_pkg::STATUS_GOOD)
      else $error("payload word with nonzero status");

   // A frame-end word has no data and no index
   a_end_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == gbfp_pkg::KIND_END) |-> (rsp_data == 8'd0 && rsp_byte_index == 16'd0))
      else $error("frame-end word with data or index");

   // After a frame end the parser hunts again
   a_end_resync : assert property (@(posedge clock) disable iff (reset)
      (advance && has_result && result_in.kind == gbfp_pkg::KIND_END)
      |=> state_ff.phase == gbfp_pkg::PH_SYNC1)
      else $error("parser did not resync after frame end");

   // The payload count stays below the declared length
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == gbfp_pkg::PH_PAYLOAD |-> state_ff.payload_count < state_ff.cur_length)
      else $error("payload count reached declared length inside payload");

   // A stalled result with a byte stuck behind it is not overwritten
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_ff)))
      else $error("pending result lost");

endmodule
